// ===== rtl/gqtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gqtc_pkg: shared types for the quadratic tone curve
// Register map, control point bundle and coefficient status word.
// ----------------------------------------------------------------------------
package gqtc_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int COEF_W     = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_IN   = 3'd0,
    REG_LOW_OUT  = 3'd1,
    REG_MID_IN   = 3'd2,
    REG_MID_OUT  = 3'd3,
    REG_HIGH_IN  = 3'd4,
    REG_HIGH_OUT = 3'd5
  } reg_idx_e;

  // control points as written through the config port
  typedef struct packed {
    logic [PIX_W-1:0] low_in;
    logic [PIX_W-1:0] low_out;
    logic [PIX_W-1:0] mid_in;
    logic [PIX_W-1:0] mid_out;
    logic [PIX_W-1:0] high_in;
    logic [PIX_W-1:0] high_out;
  } cfg_t;

  // Newton coefficients, signed fixed point, plus recompute status
  typedef struct packed {
    logic                     busy;
    logic signed [COEF_W-1:0] first;
    logic signed [COEF_W-1:0] second;
  } coef_t;

endpackage

// ===== rtl/gqtc_coef.sv =====
// ----------------------------------------------------------------------------
// gqtc_coef: Newton coefficient sequencer
// Three bit-serial divisions on one shared divider: first divided difference,
// second one, then their difference over the full input span.
// ----------------------------------------------------------------------------
module gqtc_coef
  import gqtc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  cfg_t  cfg_i,
  output coef_t coef_o
);

  // numerator magnitude: 8 integer bits, fraction, one bit of headroom
  localparam int NW = COEF_FRAC_BITS + PIX_W + 1;
  localparam int CW = $clog2(NW);
  localparam int SW = (NW + 1 > COEF_W + 1) ? NW + 1 : COEF_W + 1;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_D01,
    ST_D12,
    ST_C2
  } step_e;

  step_e                    step_q;
  logic [NW-1:0]            num_q;
  logic [PIX_W-1:0]         rem_q;
  logic [PIX_W-1:0]         div_q;
  logic                     neg_q;
  logic [CW-1:0]            cnt_q;
  logic signed [NW:0]       d01_q;
  logic signed [COEF_W-1:0] c1_q;
  logic signed [COEF_W-1:0] c2_q;

  logic [PIX_W:0]           rem_sh;
  logic [PIX_W:0]           rem_sub;
  logic                     ge;
  logic [PIX_W-1:0]         rem_nx;
  logic [NW-1:0]            quo;
  logic signed [NW:0]       q_signed;
  logic signed [SW-1:0]     q_ext;
  logic [COEF_W-1:0]        sat_res;
  logic signed [NW+1:0]     diff;
  logic [NW+1:0]            diff_abs;
  logic [PIX_W-1:0]         mag01;
  logic [PIX_W-1:0]         mag12;

  // one restoring step
  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = (rem_sh >= {1'b0, div_q});
  assign rem_nx  = ge ? rem_sub[PIX_W-1:0] : rem_sh[PIX_W-1:0];
  assign quo     = {num_q[NW-2:0], ge};

  // truncation toward zero: divide magnitudes, then apply the sign
  assign q_signed = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign q_ext    = SW'(q_signed);
  assign sat_res  = (q_ext > SAT_MAX) ? SAT_MAX[COEF_W-1:0] :
                    (q_ext < SAT_MIN) ? SAT_MIN[COEF_W-1:0] : q_ext[COEF_W-1:0];

  // d12 - d01 on unsaturated values
  assign diff     = (NW+2)'(q_signed) - (NW+2)'(d01_q);
  assign diff_abs = diff[NW+1] ? -diff : diff;

  assign mag01 = (cfg_i.mid_out >= cfg_i.low_out) ? cfg_i.mid_out - cfg_i.low_out
                                                  : cfg_i.low_out - cfg_i.mid_out;
  assign mag12 = (cfg_i.high_out >= cfg_i.mid_out) ? cfg_i.high_out - cfg_i.mid_out
                                                   : cfg_i.mid_out - cfg_i.high_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      num_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      d01_q  <= '0;
      // reset points give a straight line: slope one, no bend
      c1_q   <= COEF_W'(1) << COEF_FRAC_BITS;
      c2_q   <= '0;
    end else if (start_i) begin
      // registers change at this edge; pick them up next cycle
      step_q <= ST_LOAD;
    end else begin
      case (step_q)
        ST_IDLE: begin
          step_q <= ST_IDLE;
        end
        ST_LOAD: begin
          num_q  <= NW'(mag01) << COEF_FRAC_BITS;
          rem_q  <= '0;
          div_q  <= cfg_i.mid_in - cfg_i.low_in;
          neg_q  <= (cfg_i.mid_out < cfg_i.low_out);
          cnt_q  <= CW'(NW - 1);
          step_q <= ST_D01;
        end
        ST_D01: begin
          num_q <= quo;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            c1_q   <= sat_res;
            d01_q  <= q_signed;
            num_q  <= NW'(mag12) << COEF_FRAC_BITS;
            rem_q  <= '0;
            div_q  <= cfg_i.high_in - cfg_i.mid_in;
            neg_q  <= (cfg_i.high_out < cfg_i.mid_out);
            cnt_q  <= CW'(NW - 1);
            step_q <= ST_D12;
          end
        end
        ST_D12: begin
          num_q <= quo;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            num_q  <= diff_abs[NW-1:0];
            rem_q  <= '0;
            div_q  <= cfg_i.high_in - cfg_i.low_in;
            neg_q  <= diff[NW+1];
            cnt_q  <= CW'(NW - 1);
            step_q <= ST_C2;
          end
        end
        ST_C2: begin
          num_q <= quo;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            c2_q   <= sat_res;
            step_q <= ST_IDLE;
          end
        end
        default: begin
          step_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign coef_o.busy   = (step_q != ST_IDLE);
  assign coef_o.first  = c1_q;
  assign coef_o.second = c2_q;

endmodule

// ===== rtl/gray_quadratic_tone_curve_top.sv =====
// ----------------------------------------------------------------------------
// gray_quadratic_tone_curve_top: quadratic tone curve for 8-bit gray pixels
// Three control points define a Newton-form parabola; pixels are mapped and
// clamped in a five-register pipeline.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one pixel word per handshake, tdata = pixel, tlast = frame end.
//  - m_axis: one mapped word per input word, same order; tdata = pixel,
//    tlast = frame end copy, tuser = bad-points flag.
//  - cfg: write enable, register index 0..5, 8-bit data; index 6/7 ignored.
//  - Throughput: one word per clock while m_axis_tready is high and no
//    config write or recompute runs. Stages from accept to m_axis_tvalid:
//    input compare, two multiplier stages, sum, clamp/select.
//  - A config write reruns the coefficient sequencer: a load step, then
//    three bit-serial divisions of COEF_FRAC_BITS+9 quotient bits each.
//    s_axis_tready stays low while it runs and during the write cycle.
//  - Reset clears all valid bits and loads the default points
//    (0,0) (128,128) (255,255) with their coefficients; no recompute needed.
//  - Receiver stall: each stage holds while the one after it is full and
//    stalled, bubbles are squeezed out; on a stall tready drops only when
//    every stage is full.
// ----------------------------------------------------------------------------
module gray_quadratic_tone_curve_top
  import gqtc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic                  s_axis_tlast,   // frame_end_in
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                  m_axis_tlast,   // frame_end_out
  output logic                  m_axis_tuser,   // [0] points_invalid
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [PIX_W-1:0]      cfg_wdata_i
);

  // curve value: 32x18 product plus two smaller terms, with headroom
  localparam int VW = COEF_W + 20;

  typedef enum logic [2:0] {
    SEL_LOW,
    SEL_HIGH,
    SEL_MID,
    SEL_BAD,
    SEL_CURVE
  } sel_e;

  typedef struct packed {
    sel_e sel;
    logic fe;
  } tag_t;

  // ---------------- config registers and coefficients ----------------
  cfg_t  cfg_q;
  coef_t coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_in   <= 8'd0;
      cfg_q.low_out  <= 8'd0;
      cfg_q.mid_in   <= 8'd128;
      cfg_q.mid_out  <= 8'd128;
      cfg_q.high_in  <= 8'd255;
      cfg_q.high_out <= 8'd255;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_LOW_IN:   cfg_q.low_in   <= cfg_wdata_i;
        REG_LOW_OUT:  cfg_q.low_out  <= cfg_wdata_i;
        REG_MID_IN:   cfg_q.mid_in   <= cfg_wdata_i;
        REG_MID_OUT:  cfg_q.mid_out  <= cfg_wdata_i;
        REG_HIGH_IN:  cfg_q.high_in  <= cfg_wdata_i;
        REG_HIGH_OUT: cfg_q.high_out <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  gqtc_coef #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_we_i),
    .cfg_i  (cfg_q),
    .coef_o (coef)
  );

  // ---------------- stage enables ----------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic en_o, en4, en3, en2, en1;
  logic in_acc;

  assign en_o = !out_vld_q || m_axis_tready;
  assign en4  = !s4_vld_q || en_o;
  assign en3  = !s3_vld_q || en4;
  assign en2  = !s2_vld_q || en3;
  assign en1  = !s1_vld_q || en2;

  assign s_axis_tready = en1 && !coef.busy && !cfg_we_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1)  s1_vld_q  <= in_acc;
      if (en2)  s2_vld_q  <= s1_vld_q;
      if (en3)  s3_vld_q  <= s2_vld_q;
      if (en4)  s4_vld_q  <= s3_vld_q;
      if (en_o) out_vld_q <= s4_vld_q;
    end
  end

  // ---------------- stage 1: range tests and offsets ----------------
  logic              pts_ok;
  sel_e              sel_in;
  logic [PIX_W-1:0]  t0_in;
  logic signed [8:0] t1_in;

  assign pts_ok = (cfg_q.low_in < cfg_q.mid_in) && (cfg_q.mid_in < cfg_q.high_in);
  assign t0_in  = s_axis_tdata - cfg_q.low_in;
  assign t1_in  = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, cfg_q.mid_in});

  always_comb begin
    if (s_axis_tdata <= cfg_q.low_in) begin
      sel_in = SEL_LOW;
    end else if (s_axis_tdata >= cfg_q.high_in) begin
      sel_in = SEL_HIGH;
    end else if (s_axis_tdata == cfg_q.mid_in) begin
      sel_in = SEL_MID;
    end else if (!pts_ok) begin
      sel_in = SEL_BAD;
    end else begin
      sel_in = SEL_CURVE;
    end
  end

  tag_t              s1_tag_q;
  logic [PIX_W-1:0]  s1_t0_q;
  logic signed [8:0] s1_t1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_tag_q <= '{sel: sel_in, fe: s_axis_tlast};
      s1_t0_q  <= t0_in;
      s1_t1_q  <= t1_in;
    end
  end

  // ---------------- stage 2: c1*t0 and t0*t1 ----------------
  logic signed [COEF_W+8:0] m1_d;
  logic signed [17:0]       t01_d;
  tag_t                     s2_tag_q;
  logic signed [COEF_W+8:0] s2_m1_q;
  logic signed [17:0]       s2_t01_q;

  assign m1_d  = coef.first * $signed({1'b0, s1_t0_q});
  assign t01_d = $signed({1'b0, s1_t0_q}) * s1_t1_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_tag_q <= s1_tag_q;
      s2_m1_q  <= m1_d;
      s2_t01_q <= t01_d;
    end
  end

  // ---------------- stage 3: c2*(t0*t1) ----------------
  logic signed [COEF_W+17:0] m2_d;
  tag_t                      s3_tag_q;
  logic signed [COEF_W+8:0]  s3_m1_q;
  logic signed [COEF_W+17:0] s3_m2_q;

  assign m2_d = coef.second * s2_t01_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_tag_q <= s2_tag_q;
      s3_m1_q  <= s2_m1_q;
      s3_m2_q  <= m2_d;
    end
  end

  // ---------------- stage 4: sum ----------------
  logic signed [VW-1:0] lo_fix;
  logic signed [VW-1:0] hi_fix;
  logic signed [VW-1:0] v_d;
  tag_t                 s4_tag_q;
  logic signed [VW-1:0] s4_v_q;

  assign lo_fix = VW'(cfg_q.low_out) << COEF_FRAC_BITS;
  assign hi_fix = VW'(cfg_q.high_out) << COEF_FRAC_BITS;
  assign v_d    = lo_fix + VW'(s3_m1_q) + VW'(s3_m2_q);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_tag_q <= s3_tag_q;
      s4_v_q   <= v_d;
    end
  end

  // ---------------- stage 5: clamp, select, output register ----------------
  logic [PIX_W-1:0] curve;
  logic [PIX_W-1:0] pix_d;
  logic             bad_d;

  // upper clamp first, so swapped end outputs still give high_out
  always_comb begin
    if (s4_v_q >= hi_fix) begin
      curve = cfg_q.high_out;
    end else if (s4_v_q <= lo_fix) begin
      curve = cfg_q.low_out;
    end else begin
      curve = s4_v_q[COEF_FRAC_BITS +: PIX_W];
    end
  end

  always_comb begin
    bad_d = 1'b0;
    case (s4_tag_q.sel)
      SEL_LOW:   pix_d = cfg_q.low_out;
      SEL_HIGH:  pix_d = cfg_q.high_out;
      SEL_MID:   pix_d = cfg_q.mid_out;
      SEL_BAD: begin
        pix_d = cfg_q.low_out;
        bad_d = 1'b1;
      end
      SEL_CURVE: pix_d = curve;
      default:   pix_d = cfg_q.low_out;
    endcase
  end

  logic [PIX_W-1:0] out_pix_q;
  logic             out_fe_q;
  logic             out_bad_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_pix_q <= pix_d;
      out_fe_q  <= s4_tag_q.fe;
      out_bad_q <= bad_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_fe_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

// ===== rtl/gqtc_checker.sv =====
// ----------------------------------------------------------------------------
// gqtc_checker: port-level checks for the tone curve block
// Output hold under stall, input blocking around config writes, reset.
// ----------------------------------------------------------------------------
module gqtc_checker
  import gqtc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic             m_axis_tuser,
  input logic             cfg_we_i
);

  // stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // no pixel taken on a config write
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !s_axis_tready)
    else $error("input accepted during config write");

  // coefficient recompute keeps input closed after a write
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input open right after config write");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind gray_quadratic_tone_curve_top gqtc_checker u_gqtc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser),
  .cfg_we_i     (cfg_we_i)
);
